// ===== sv/fcem_pkg.sv =====
`default_nettype none
package fcem_pkg;

  // map geometry
  localparam int MAP_ENTRIES = 8;
  localparam int RUN_LIMIT   = 255;

  // derived widths
  localparam int IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAP_ENTRIES + 1);
  localparam int EXTRA_W = $clog2(RUN_LIMIT + 1);

  // field widths
  localparam int DATA_W     = 32;
  localparam int SHIFT_W    = 3;
  localparam int START_W    = 28;
  localparam int BLK_W      = 23;
  localparam int SEC_W      = (1 << SHIFT_W) - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // end-of-chain marks
  localparam logic [DATA_W-1:0] END32_MASK = 32'h0fff_fff8;
  localparam logic [15:0]       END16_MASK = 16'hfff8;

  // first data cluster number
  localparam logic [DATA_W-1:0] FIRST_CLUSTER = 32'd2;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_CHAIN  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_BLOCK = 2'd1,
    STS_MAP_SMALL = 2'd2,
    STS_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_START    = 3'd0,
    CFG_CLUSTER_SHIFT = 3'd1,
    CFG_FAT32_MODE    = 3'd2,
    CFG_START_CLUSTER = 3'd3,
    CFG_BLOCK_COUNT   = 3'd4
  } cfg_idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    begin_map;
    logic    chain_end;
    logic    chain_ext;
    logic    chain_open;
    logic    chain_fail;
    logic    lk_start;
    logic    lk_step;
    logic    lk_hit;
    logic    lk_fin;
    logic    out_load;
    status_t out_status;
  } fcem_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic chain_ign;
    logic chain_end;
    logic chain_ext;
    logic map_full;
    logic lk_bad;
    logic lk_empty;
    logic lk_hit;
    logic lk_last;
  } fcem_sts_t;

endpackage
`default_nettype wire

// ===== sv/fcem_ctrl.sv =====
`default_nettype none
module fcem_ctrl
  import fcem_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic [1:0] in_op,
  input  wire fcem_sts_t sts,
  output fcem_cmd_t      cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // decode the word and sequence the extent walk
  always_comb begin
    cmd       = '0;
    cmd.out_status = STS_OK;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(in_op))
            OP_BEGIN: begin
              cmd.begin_map = 1'b1;
              cmd.out_load  = 1'b1;
            end
            OP_CHAIN: begin
              cmd.out_load = 1'b1;
              priority if (sts.chain_ign) begin
                cmd.out_status = STS_IGNORED;
              end else if (sts.chain_end) begin
                cmd.chain_end = 1'b1;
              end else if (sts.chain_ext) begin
                cmd.chain_ext = 1'b1;
              end else if (sts.map_full) begin
                cmd.chain_fail = 1'b1;
                cmd.out_status = STS_MAP_SMALL;
              end else begin
                cmd.chain_open = 1'b1;
              end
            end
            OP_LOOKUP: begin
              priority if (sts.lk_bad) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STS_BAD_BLOCK;
              end else if (sts.lk_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = STS_MAP_SMALL;
              end else begin
                cmd.lk_start = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
            default: begin
              cmd.out_load   = 1'b1;
              cmd.out_status = STS_IGNORED;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (sts.lk_hit) begin
          cmd.lk_hit = 1'b1;
          state_nxt  = S_FIN;
        end else if (sts.lk_last) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = STS_MAP_SMALL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.lk_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.lk_fin   = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the sector add is only ever entered from an extent hit
  a_fin_follows_hit : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> $past(state_r == S_SCAN && sts.lk_hit))
    else $error("sector add entered without an extent hit");

endmodule
`default_nettype wire

// ===== sv/fcem_dpath.sv =====
`default_nettype none
module fcem_dpath
  import fcem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [DATA_W-1:0]     in_chain_value,
  input  wire logic [BLK_W-1:0]      in_block_number,
  input  wire fcem_cmd_t             cmd,
  output fcem_sts_t                  sts,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [DATA_W-1:0]          out_sector_address,
  output logic                       out_map_complete
);

  // configuration registers
  logic [DATA_W-1:0]  data_start_r;
  logic [SHIFT_W-1:0] cluster_shift_r;
  logic               fat32_mode_r;
  logic [START_W-1:0] start_cluster_r;
  logic [BLK_W-1:0]   block_count_r;

  // map state
  logic [DATA_W-1:0]  first_mem [MAP_ENTRIES];
  logic [EXTRA_W-1:0] extra_mem [MAP_ENTRIES];
  logic [CNT_W-1:0]   entries_r, entries_nxt;
  logic [DATA_W-1:0]  last_r, last_nxt;
  logic [EXTRA_W-1:0] cur_extra_r, cur_extra_nxt;
  logic               done_r, done_nxt;
  logic               failed_r, failed_nxt;

  // lookup walk
  logic [IDX_W-1:0]   idx_r;
  logic [BLK_W-1:0]   clu_r;
  logic [SEC_W-1:0]   sec_r;
  logic [DATA_W-1:0]  rd_first_r;
  logic [EXTRA_W-1:0] rd_extra_r;
  logic [DATA_W-1:0]  cl_m2_r;

  // result word
  logic               out_valid_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  out_sector_r;
  logic               out_complete_r;

  logic [DATA_W-1:0]  chain_v;
  logic               end32;
  logic               end16;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   open_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic [BLK_W-1:0]   rd_extra_ext;
  logic [DATA_W-1:0]  sector;

  // capture configuration words; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r    <= '0;
      cluster_shift_r <= '0;
      fat32_mode_r    <= 1'b1;
      start_cluster_r <= START_W'(2);
      block_count_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DATA_START:    data_start_r    <= cfg_data;
        CFG_CLUSTER_SHIFT: cluster_shift_r <= cfg_data[SHIFT_W-1:0];
        CFG_FAT32_MODE:    fat32_mode_r    <= cfg_data[0];
        CFG_START_CLUSTER: start_cluster_r <= cfg_data[START_W-1:0];
        CFG_BLOCK_COUNT:   block_count_r   <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // classify the chain word
  assign chain_v = fat32_mode_r ? in_chain_value : {16'h0000, in_chain_value[15:0]};
  assign end32   = (in_chain_value & END32_MASK) == END32_MASK;
  assign end16   = (in_chain_value[15:0] & END16_MASK) == END16_MASK;

  assign cur_idx      = IDX_W'(entries_r - CNT_W'(1));
  assign open_idx     = IDX_W'(entries_r);
  assign rd_extra_ext = {{(BLK_W-EXTRA_W){1'b0}}, rd_extra_r};

  always_comb begin
    sts.chain_ign = (entries_r == '0) || done_r || failed_r;
    sts.chain_end = fat32_mode_r ? end32 : end16;
    sts.chain_ext = (chain_v == last_r + DATA_W'(1)) && (cur_extra_r < EXTRA_W'(RUN_LIMIT));
    sts.map_full  = (entries_r >= CNT_W'(MAP_ENTRIES));
    sts.lk_bad    = (in_block_number >= block_count_r);
    sts.lk_empty  = (entries_r == '0);
    sts.lk_hit    = (clu_r <= rd_extra_ext);
    sts.lk_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == entries_r);
  end

  // next map state
  always_comb begin
    entries_nxt   = entries_r;
    last_nxt      = last_r;
    cur_extra_nxt = cur_extra_r;
    done_nxt      = done_r;
    failed_nxt    = failed_r;
    if (cmd.begin_map) begin
      entries_nxt   = CNT_W'(1);
      last_nxt      = {{(DATA_W-START_W){1'b0}}, start_cluster_r};
      cur_extra_nxt = '0;
      failed_nxt    = 1'b0;
      done_nxt      = ({1'b0, block_count_r} <= ((BLK_W+1)'(1) << cluster_shift_r));
    end
    if (cmd.chain_end) done_nxt = 1'b1;
    if (cmd.chain_ext) begin
      last_nxt      = chain_v;
      cur_extra_nxt = cur_extra_r + EXTRA_W'(1);
    end
    if (cmd.chain_open) begin
      entries_nxt   = entries_r + CNT_W'(1);
      last_nxt      = chain_v;
      cur_extra_nxt = '0;
    end
    if (cmd.chain_fail) failed_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      last_r      <= '0;
      cur_extra_r <= '0;
      done_r      <= 1'b0;
      failed_r    <= 1'b0;
    end else begin
      entries_r   <= entries_nxt;
      last_r      <= last_nxt;
      cur_extra_r <= cur_extra_nxt;
      done_r      <= done_nxt;
      failed_r    <= failed_nxt;
    end
  end

  // write extents: seed, extend the current run or open a new one
  always_ff @(posedge clk) begin
    if (cmd.begin_map) begin
      first_mem[0] <= {{(DATA_W-START_W){1'b0}}, start_cluster_r};
      extra_mem[0] <= '0;
    end else if (cmd.chain_open) begin
      first_mem[open_idx] <= chain_v;
      extra_mem[open_idx] <= '0;
    end else if (cmd.chain_ext) begin
      extra_mem[cur_idx] <= cur_extra_r + EXTRA_W'(1);
    end
  end

  // read the extent that the walk looks at next
  assign rd_en   = cmd.lk_start | cmd.lk_step;
  assign rd_addr = cmd.lk_start ? '0 : idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_first_r <= first_mem[rd_addr];
      rd_extra_r <= extra_mem[rd_addr];
    end
  end

  // walk the extents, one a cycle
  always_ff @(posedge clk) begin
    if (cmd.lk_start) begin
      idx_r <= '0;
      clu_r <= in_block_number >> cluster_shift_r;
      sec_r <= in_block_number[SEC_W-1:0] & ~({SEC_W{1'b1}} << cluster_shift_r);
    end else if (cmd.lk_step) begin
      idx_r <= idx_r + IDX_W'(1);
      clu_r <= clu_r - (rd_extra_ext + BLK_W'(1));
    end
    if (cmd.lk_hit) begin
      cl_m2_r <= rd_first_r + {{(DATA_W-BLK_W){1'b0}}, clu_r} - FIRST_CLUSTER;
    end
  end

  // sector within cluster never reaches above the shift, so it is or-ed in
  assign sector = data_start_r
                + ((cl_m2_r << cluster_shift_r) | {{(DATA_W-SEC_W){1'b0}}, sec_r});

  // load the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
    if (cmd.out_load) begin
      out_status_r   <= cmd.out_status;
      out_sector_r   <= cmd.lk_fin ? sector : '0;
      out_complete_r <= done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_sector_address = out_sector_r;
  assign out_map_complete   = out_complete_r;

  a_entries_bound : assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= CNT_W'(MAP_ENTRIES))
    else $error("extent count beyond map size");

  a_run_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cur_extra_r <= EXTRA_W'(RUN_LIMIT))
    else $error("run length beyond limit");

  a_failed_full : assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (entries_r == CNT_W'(MAP_ENTRIES)))
    else $error("map failure flagged with free extents");

  a_sector_only_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STS_OK) |-> (out_sector_r == '0))
    else $error("sector driven on a failed word");

endmodule
`default_nettype wire

// ===== sv/fat_cluster_extent_map.sv =====
`default_nettype none
// FAT cluster chain extent map. A begin word seeds the map with the start
// cluster, chain words extend it, and lookup words turn a file block into a
// disk sector. Every accepted word gives exactly one result word, shown on
// the out_ ports for one cycle with out_valid high, and the result cannot be
// held off. Begin, chain, unknown-op and rejected lookups leave busy low, and
// the result appears on the next cycle. A lookup walks the extent store one
// entry per cycle through its single registered read port. When the block
// lies in extent k (1 to 8), the walk is followed by the sector add before
// the result is loaded. A lookup that runs past all k built extents skips
// the add. The user must write configuration only while idle; the block
// itself does not enforce it.
module fat_cluster_extent_map
  import fcem_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_op,
  input  wire logic [DATA_W-1:0]     in_chain_value,
  input  wire logic [BLK_W-1:0]      in_block_number,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [DATA_W-1:0]          out_sector_address,
  output logic                       out_map_complete,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fcem_cmd_t cmd;
  fcem_sts_t sts;

  fcem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fcem_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_chain_value     (in_chain_value),
    .in_block_number    (in_block_number),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_sector_address (out_sector_address),
    .out_map_complete   (out_map_complete)
  );

endmodule
`default_nettype wire
